>>> rtl/core/jprs_pkg.sv
// Shared types, codes and constants of the joint pose ramp sequencer.
package jprs_pkg;

    localparam int MAX_JOINTS_DEF    = 12;
    localparam int POSITION_BITS_DEF = 16;

    localparam int PROG_W = 17;
    localparam int GAIN_W = 16;

    localparam logic [PROG_W-1:0] FULL_RAMP       = 17'h10000;
    localparam logic [PROG_W-1:0] RAMP_STEP_RESET = 17'd131;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_TABLE   = 2'd1;
    localparam logic [1:0] CMD_REQUEST = 2'd2;

    // Pending request codes.
    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_UP   = 2'd1;
    localparam logic [1:0] REQ_RL   = 2'd2;
    localparam logic [1:0] REQ_DOWN = 2'd3;

    // Table selects of a table write.
    localparam logic [2:0] TSEL_HOME   = 3'd0;
    localparam logic [2:0] TSEL_HOLD_P = 3'd1;
    localparam logic [2:0] TSEL_HOLD_D = 3'd2;
    localparam logic [2:0] TSEL_RUN_P  = 3'd3;
    localparam logic [2:0] TSEL_RUN_D  = 3'd4;

    // Phase codes as reported on the result channel.
    localparam logic [2:0] PHASE_WAIT    = 3'd0;
    localparam logic [2:0] PHASE_UP      = 3'd1;
    localparam logic [2:0] PHASE_RL_INIT = 3'd2;
    localparam logic [2:0] PHASE_RUN     = 3'd3;
    localparam logic [2:0] PHASE_DOWN    = 3'd4;

    // Lanes of the pose memory word.
    localparam int POSE_ORIGIN = 0;
    localparam int POSE_REST   = 1;
    localparam int POSE_HOME   = 2;

    // Lanes of the gain memory word.
    localparam int GAIN_HOLD_P = 0;
    localparam int GAIN_HOLD_D = 1;
    localparam int GAIN_RUN_P  = 2;
    localparam int GAIN_RUN_D  = 3;

    typedef enum logic [4:0] {
        MODE_WAIT    = 5'b00001,
        MODE_UP      = 5'b00010,
        MODE_RL_INIT = 5'b00100,
        MODE_RUN     = 5'b01000,
        MODE_DOWN    = 5'b10000
    } mode_t;

    // How the result of a sample is formed once the tables have been read.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_MEAS,
        KIND_RUN,
        KIND_RAMP_UP,
        KIND_RAMP_DOWN
    } out_kind_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] joint;
        logic       last;
    } item_tag_t;

    function automatic logic [2:0] mode_to_phase(input mode_t mode);
        logic [2:0] code;
        unique case (mode)
            MODE_WAIT:    code = PHASE_WAIT;
            MODE_UP:      code = PHASE_UP;
            MODE_RL_INIT: code = PHASE_RL_INIT;
            MODE_RUN:     code = PHASE_RUN;
            MODE_DOWN:    code = PHASE_DOWN;
            default:      code = PHASE_WAIT;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/joint_pose_ramp_sequencer_core.sv
// Top level of the joint pose ramp sequencer: phase control, pose and gain memories, ramp pipe.
//
// The s_ channel carries one transaction per joint sample, table write or request write;
// s_tuser selects which (command) and, for a table write, the table. s_tlast marks the last
// joint sample of a control tick, at which phase changes and ramp progress take effect.
// The m_ channel returns exactly one transaction per accepted input transaction, in order.
// Configuration: cfg_we writes cfg_wdata into the ramp step register; write only while idle.
// Results pass stages 1 to 3 and the output register. Throughput is one transaction per cycle
// unless the output stalls: the phase state sits in registers, the per-joint tables sit in
// two memories read into registers at acceptance, and the ramp interpolation is one multiply
// pipelined over the remaining stages. A write by one transaction is seen by the next.
// Reset clears the phase to waiting, the pending request and both ramp progress values,
// empties the pipeline and sets the ramp step to 131; the tables are not cleared and must
// be written before they are used. When m_tvalid is high and the receiver holds m_tready
// low, the whole pipeline holds and s_tready falls in the same cycle; no transaction is lost.
module joint_pose_ramp_sequencer_core #(
    parameter int MAX_JOINTS    = jprs_pkg::MAX_JOINTS_DEF,
    parameter int POSITION_BITS = jprs_pkg::POSITION_BITS_DEF,
    localparam int P          = POSITION_BITS,
    localparam int S_FIELDS_W = 4 + 2 * P + 16 + 2,
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8,
    localparam int M_FIELDS_W = P + 2 * jprs_pkg::GAIN_W + 3 + 4,
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [16:0]           cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // joint_index, measured_position, policy_position, table_word, request
    input  logic [S_DATA_W-1:0]   s_tdata,
    // command, table_select
    input  logic [4:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // target_position, stiffness, damping, phase, out_joint
    output logic [M_DATA_W-1:0]   m_tdata,
    // position_valid, gains_valid
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int ADDR_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int PW     = P + 19;
    localparam int PROG_W = jprs_pkg::PROG_W;
    localparam int GAIN_W = jprs_pkg::GAIN_W;

    localparam int OFS_MEAS = 4;
    localparam int OFS_POL  = OFS_MEAS + P;
    localparam int OFS_WORD = OFS_POL + P;
    localparam int OFS_REQ  = OFS_WORD + 16;

    localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);

    // Input fields.
    logic [1:0]  s_command;
    logic [2:0]  s_table_select;
    logic [3:0]  s_joint_index;
    logic [P-1:0] s_measured;
    logic [P-1:0] s_policy;
    logic [15:0] s_table_word;
    logic [1:0]  s_request;

    assign s_command      = s_tuser[1:0];
    assign s_table_select = s_tuser[4:2];
    assign s_joint_index  = s_tdata[3:0];
    assign s_measured     = s_tdata[OFS_MEAS +: P];
    assign s_policy       = s_tdata[OFS_POL +: P];
    assign s_table_word   = s_tdata[OFS_WORD +: 16];
    assign s_request      = s_tdata[OFS_REQ +: 2];

    logic pipe_en;
    logic s_accept;
    logic joint_ok;
    logic [ADDR_W-1:0] s_addr;

    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;
    assign s_accept = s_tvalid && pipe_en;
    assign joint_ok = (32'(s_joint_index) < MAX_JOINTS);
    assign s_addr   = ADDR_W'(s_joint_index);

    // Phase control state.
    jprs_pkg::mode_t     mode_reg, mode_next;
    logic [1:0]          pend_reg, pend_next;
    logic [PROG_W-1:0]   up_reg, up_next;
    logic [PROG_W-1:0]   down_reg, down_next;
    logic [PROG_W-1:0]   step_reg;

    logic [PROG_W:0]     up_sum, down_sum;
    logic [PROG_W-1:0]   up_adv, down_adv, ramp_prog;
    logic                up_open, down_open;
    logic                cap_origin, cap_rest;
    jprs_pkg::out_kind_t kind;

    assign up_sum    = {1'b0, up_reg} + {1'b0, step_reg};
    assign down_sum  = {1'b0, down_reg} + {1'b0, step_reg};
    assign up_adv    = (up_sum > {1'b0, jprs_pkg::FULL_RAMP}) ? jprs_pkg::FULL_RAMP
                                                             : up_sum[PROG_W-1:0];
    assign down_adv  = (down_sum > {1'b0, jprs_pkg::FULL_RAMP}) ? jprs_pkg::FULL_RAMP
                                                                 : down_sum[PROG_W-1:0];
    assign up_open   = (up_reg < jprs_pkg::FULL_RAMP);
    assign down_open = (down_reg < jprs_pkg::FULL_RAMP);

    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        up_next    = up_reg;
        down_next  = down_reg;
        cap_origin = 1'b0;
        cap_rest   = 1'b0;
        kind       = jprs_pkg::KIND_NONE;
        ramp_prog  = up_adv;
        case (s_command)
            jprs_pkg::CMD_REQUEST: begin
                pend_next = s_request;
            end
            jprs_pkg::CMD_SAMPLE: begin
                unique case (mode_reg)
                    jprs_pkg::MODE_WAIT: begin
                        if (joint_ok) begin
                            kind = jprs_pkg::KIND_MEAS;
                            if (pend_reg == jprs_pkg::REQ_UP) begin
                                cap_origin = 1'b1;
                                cap_rest   = 1'b1;
                            end
                        end
                        if (s_tlast && pend_reg == jprs_pkg::REQ_UP) begin
                            pend_next = jprs_pkg::REQ_NONE;
                            up_next   = '0;
                            mode_next = jprs_pkg::MODE_UP;
                        end
                    end
                    jprs_pkg::MODE_UP: begin
                        if (up_open && joint_ok) begin
                            kind = jprs_pkg::KIND_RAMP_UP;
                        end
                        if (joint_ok && pend_reg == jprs_pkg::REQ_DOWN) begin
                            cap_origin = 1'b1;
                        end
                        if (s_tlast) begin
                            if (up_open) begin
                                up_next = up_adv;
                            end
                            if (pend_reg == jprs_pkg::REQ_RL) begin
                                pend_next = jprs_pkg::REQ_NONE;
                                mode_next = jprs_pkg::MODE_RL_INIT;
                            end else if (pend_reg == jprs_pkg::REQ_DOWN) begin
                                pend_next = jprs_pkg::REQ_NONE;
                                down_next = '0;
                                mode_next = jprs_pkg::MODE_DOWN;
                            end
                        end
                    end
                    jprs_pkg::MODE_RL_INIT: begin
                        if (s_tlast && up_reg == jprs_pkg::FULL_RAMP) begin
                            pend_next = jprs_pkg::REQ_NONE;
                            mode_next = jprs_pkg::MODE_RUN;
                        end
                    end
                    jprs_pkg::MODE_RUN: begin
                        if (joint_ok) begin
                            kind = jprs_pkg::KIND_RUN;
                            if (pend_reg == jprs_pkg::REQ_DOWN || pend_reg == jprs_pkg::REQ_UP) begin
                                cap_origin = 1'b1;
                            end
                        end
                        if (s_tlast) begin
                            if (pend_reg == jprs_pkg::REQ_DOWN) begin
                                pend_next = jprs_pkg::REQ_NONE;
                                down_next = '0;
                                mode_next = jprs_pkg::MODE_DOWN;
                            end else if (pend_reg == jprs_pkg::REQ_UP) begin
                                pend_next = jprs_pkg::REQ_NONE;
                                up_next   = '0;
                                mode_next = jprs_pkg::MODE_UP;
                            end
                        end
                    end
                    jprs_pkg::MODE_DOWN: begin
                        ramp_prog = down_adv;
                        if (down_open && joint_ok) begin
                            kind = jprs_pkg::KIND_RAMP_DOWN;
                        end
                        if (s_tlast) begin
                            // The move to waiting looks at the progress after this tick.
                            if (down_open) begin
                                down_next = down_adv;
                            end
                            if (down_next == jprs_pkg::FULL_RAMP) begin
                                pend_next = jprs_pkg::REQ_NONE;
                                mode_next = jprs_pkg::MODE_WAIT;
                            end
                        end
                    end
                    default: begin
                        mode_next = jprs_pkg::MODE_WAIT;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= jprs_pkg::MODE_WAIT;
            pend_reg <= jprs_pkg::REQ_NONE;
            up_reg   <= '0;
            down_reg <= '0;
            step_reg <= jprs_pkg::RAMP_STEP_RESET;
        end else begin
            if (s_accept) begin
                mode_reg <= mode_next;
                pend_reg <= pend_next;
                up_reg   <= up_next;
                down_reg <= down_next;
            end
            if (cfg_we) begin
                step_reg <= cfg_wdata;
            end
        end
    end

    // Pose memory (origin, rest, home) and gain memory (hold and run gains).
    // Both are read at acceptance; a write by a transaction lands at its own
    // acceptance edge, so every later transaction reads the updated entry.
    logic [2:0][P-1:0]      pose_mem [MAX_JOINTS];
    logic [3:0][GAIN_W-1:0] gain_mem [MAX_JOINTS];
    logic [2:0][P-1:0]      pose_rd_reg;
    logic [3:0][GAIN_W-1:0] gain_rd_reg;
    logic                   table_we;

    assign table_we = s_accept && joint_ok && (s_command == jprs_pkg::CMD_TABLE);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pose_rd_reg <= pose_mem[s_addr];
        end
        if (s_accept && cap_origin) begin
            pose_mem[s_addr][jprs_pkg::POSE_ORIGIN] <= s_measured;
        end
        if (s_accept && cap_rest) begin
            pose_mem[s_addr][jprs_pkg::POSE_REST] <= s_measured;
        end
        if (table_we && s_table_select == jprs_pkg::TSEL_HOME) begin
            pose_mem[s_addr][jprs_pkg::POSE_HOME] <= P'(s_table_word);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            gain_rd_reg <= gain_mem[s_addr];
        end
        if (table_we) begin
            case (s_table_select)
                jprs_pkg::TSEL_HOLD_P: gain_mem[s_addr][jprs_pkg::GAIN_HOLD_P] <= s_table_word;
                jprs_pkg::TSEL_HOLD_D: gain_mem[s_addr][jprs_pkg::GAIN_HOLD_D] <= s_table_word;
                jprs_pkg::TSEL_RUN_P:  gain_mem[s_addr][jprs_pkg::GAIN_RUN_P]  <= s_table_word;
                jprs_pkg::TSEL_RUN_D:  gain_mem[s_addr][jprs_pkg::GAIN_RUN_D]  <= s_table_word;
                default: begin
                end
            endcase
        end
    end

    // Stage 1: table data arrives.
    logic                s1_valid_reg;
    jprs_pkg::item_tag_t s1_tag_reg;
    jprs_pkg::out_kind_t s1_kind_reg;
    logic [PROG_W-1:0]   s1_prog_reg;
    logic [P-1:0]        s1_direct_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_tag_reg    <= '{phase: jprs_pkg::mode_to_phase(mode_reg),
                               joint: s_joint_index, last: s_tlast};
            s1_kind_reg   <= kind;
            s1_prog_reg   <= ramp_prog;
            s1_direct_reg <= (mode_reg == jprs_pkg::MODE_RUN) ? s_policy : s_measured;
        end
    end

    // Stage 2: pick base, ramp span and gains. Direct targets pass with a zero span.
    logic                s2_valid_reg;
    jprs_pkg::item_tag_t s2_tag_reg;
    logic                s2_pv_reg, s2_gv_reg;
    logic [P-1:0]        s2_base_reg;
    logic signed [P:0]   s2_diff_reg;
    logic [PROG_W-1:0]   s2_prog_reg;
    logic [GAIN_W-1:0]   s2_kp_reg, s2_kd_reg;

    logic [P-1:0]        base_next;
    logic [P-1:0]        goal_next;
    logic signed [P:0]   diff_next;
    logic                pv_next, gv_next, ramp_next;
    logic [GAIN_W-1:0]   kp_next, kd_next;

    always_comb begin
        base_next = '0;
        goal_next = pose_rd_reg[jprs_pkg::POSE_HOME];
        pv_next   = 1'b0;
        gv_next   = 1'b0;
        ramp_next = 1'b0;
        kp_next   = '0;
        kd_next   = '0;
        case (s1_kind_reg) inside
            jprs_pkg::KIND_MEAS: begin
                base_next = s1_direct_reg;
                pv_next   = 1'b1;
            end
            jprs_pkg::KIND_RUN: begin
                base_next = s1_direct_reg;
                pv_next   = 1'b1;
                gv_next   = 1'b1;
                kp_next   = gain_rd_reg[jprs_pkg::GAIN_RUN_P];
                kd_next   = gain_rd_reg[jprs_pkg::GAIN_RUN_D];
            end
            jprs_pkg::KIND_RAMP_UP, jprs_pkg::KIND_RAMP_DOWN: begin
                base_next = pose_rd_reg[jprs_pkg::POSE_ORIGIN];
                if (s1_kind_reg == jprs_pkg::KIND_RAMP_DOWN) begin
                    goal_next = pose_rd_reg[jprs_pkg::POSE_REST];
                end
                ramp_next = 1'b1;
                pv_next   = 1'b1;
                gv_next   = 1'b1;
                kp_next   = gain_rd_reg[jprs_pkg::GAIN_HOLD_P];
                kd_next   = gain_rd_reg[jprs_pkg::GAIN_HOLD_D];
            end
            default: begin
            end
        endcase
        if (ramp_next) begin
            diff_next = $signed({goal_next[P-1], goal_next}) - $signed({base_next[P-1], base_next});
        end else begin
            diff_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_tag_reg  <= s1_tag_reg;
            s2_pv_reg   <= pv_next;
            s2_gv_reg   <= gv_next;
            s2_base_reg <= base_next;
            s2_diff_reg <= diff_next;
            s2_prog_reg <= s1_prog_reg;
            s2_kp_reg   <= kp_next;
            s2_kd_reg   <= kd_next;
        end
    end

    // Stage 3: span times progress, biased so that a half rounds up.
    logic                s3_valid_reg;
    jprs_pkg::item_tag_t s3_tag_reg;
    logic                s3_pv_reg, s3_gv_reg;
    logic [P-1:0]        s3_base_reg;
    logic signed [PW-1:0] s3_prod_reg;
    logic [GAIN_W-1:0]   s3_kp_reg, s3_kd_reg;
    logic signed [PW-1:0] prod_next;

    // Both factors are sign-extended to the full product width before the multiply.
    assign prod_next = PW'(s2_diff_reg) * PW'($signed({1'b0, s2_prog_reg})) + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s3_tag_reg  <= s2_tag_reg;
            s3_pv_reg   <= s2_pv_reg;
            s3_gv_reg   <= s2_gv_reg;
            s3_base_reg <= s2_base_reg;
            s3_prod_reg <= prod_next;
            s3_kp_reg   <= s2_kp_reg;
            s3_kd_reg   <= s2_kd_reg;
        end
    end

    // Output register: the floor of the scaled product added to the base.
    logic                out_valid_reg;
    jprs_pkg::item_tag_t out_tag_reg;
    logic                out_pv_reg, out_gv_reg;
    logic [P-1:0]        out_target_reg;
    logic [GAIN_W-1:0]   out_kp_reg, out_kd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_tag_reg    <= s3_tag_reg;
            out_pv_reg     <= s3_pv_reg;
            out_gv_reg     <= s3_gv_reg;
            out_target_reg <= s3_base_reg + s3_prod_reg[P+15:16];
            out_kp_reg     <= s3_kp_reg;
            out_kd_reg     <= s3_kd_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_tag_reg.last;
    assign m_tuser  = {out_gv_reg, out_pv_reg};
    assign m_tdata  = M_DATA_W'({out_tag_reg.joint, out_tag_reg.phase,
                                 out_kd_reg, out_kp_reg, out_target_reg});

endmodule
